@@ src/shpd_pkg.sv @@
package shpd_pkg;

  localparam int OFFSET_DIM_DEF = 32;
  localparam int COLOR_DIM_DEF  = 128;

  localparam int COORD_W    = 12;
  localparam int SHIFT_W    = 4;
  localparam int COLOR_W    = 24;
  localparam int OFF_REG_W  = 6;
  localparam int COL_REG_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Remainder bits resolved per pipeline stage of the modulo units.
  localparam int MOD_STEP = 4;

  typedef enum logic [1:0] {
    FUNC_WR_SHIFT = 2'd0,
    FUNC_WR_COLOR = 2'd1,
    FUNC_DECODE   = 2'd2,
    FUNC_NOP      = 2'd3
  } shpd_func_e;

  typedef enum logic {
    CFG_OFFSET_SIZE = 1'b0,
    CFG_COLOR_SIZE  = 1'b1
  } shpd_cfg_e;

  typedef struct packed {
    shpd_func_e           func;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic                 occupied;
    logic [SHIFT_W-1:0]   shift_x;
    logic [SHIFT_W-1:0]   shift_y;
    logic [COLOR_W-1:0]   pixel_color;
  } shpd_in_t;

  typedef struct packed {
    logic                 present;
    logic [COLOR_W-1:0]   decoded_color;
  } shpd_out_t;

  // Command fields carried alongside the modulo pipelines.
  typedef struct packed {
    shpd_func_e           func;
    logic                 occupied;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [SHIFT_W-1:0]   shift_x;
    logic [SHIFT_W-1:0]   shift_y;
    logic [COLOR_W-1:0]   pixel_color;
  } shpd_side_t;

endpackage

@@ src/shpd_ram.sv @@
module shpd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/shpd_modpipe.sv @@
// Two lanes of pipelined restoring remainder: a mod m and b mod m.
// Each stage folds STEP dividend bits into the running remainder.
module shpd_modpipe #(
  parameter int DW   = 12,
  parameter int MW   = 6,
  parameter int SW   = 1,
  parameter int STEP = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  input  logic [MW-1:0] mod_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [MW-1:0] ra_o,
  output logic [MW-1:0] rb_o,
  output logic [SW-1:0] side_o
);

  localparam int NST = (DW + STEP - 1) / STEP;
  localparam int PW  = NST * STEP;

  logic          vld_q  [NST];
  logic [MW-1:0] ra_q   [NST];
  logic [MW-1:0] rb_q   [NST];
  logic [PW-1:0] da_q   [NST];
  logic [PW-1:0] db_q   [NST];
  logic [SW-1:0] side_q [NST];

  // The remainder stays below m, so one conditional subtract per bit suffices.
  function automatic logic [MW-1:0] mod_steps(input logic [MW-1:0] r_in,
                                              input logic [STEP-1:0] bits,
                                              input logic [MW-1:0] m);
    logic [MW:0]   t;
    logic [MW-1:0] r;
    r = r_in;
    for (int s = STEP - 1; s >= 0; s--) begin
      t = {r, bits[s]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      r = t[MW-1:0];
    end
    return r;
  endfunction

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic          v_in;
    logic [MW-1:0] ra_in;
    logic [MW-1:0] rb_in;
    logic [PW-1:0] da_in;
    logic [PW-1:0] db_in;
    logic [SW-1:0] s_in;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign ra_in = '0;
      assign rb_in = '0;
      assign da_in = PW'(a_i);
      assign db_in = PW'(b_i);
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = vld_q[k-1];
      assign ra_in = ra_q[k-1];
      assign rb_in = rb_q[k-1];
      assign da_in = da_q[k-1];
      assign db_in = db_q[k-1];
      assign s_in  = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ra_q[k]   <= mod_steps(ra_in, da_in[PW-1 -: STEP], mod_i);
      rb_q[k]   <= mod_steps(rb_in, db_in[PW-1 -: STEP], mod_i);
      da_q[k]   <= da_in << STEP;
      db_q[k]   <= db_in << STEP;
      side_q[k] <= s_in;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign ra_o    = ra_q[NST-1];
  assign rb_o    = rb_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

@@ src/spatial_hash_pixel_decoder_core.sv @@
// Perfect spatial hash decoder for sparse images.
// Command channel: a transaction is taken at each rising edge with start high and busy
// low; busy stays low, so one command enters every cycle. func selects an offset
// table write, a colour table write or a pixel decode. Out-of-table writes and
// func 3 are dropped.
// Result channel: each decode gives one transaction, done_o high for exactly one
// cycle with out_o valid; writes give none. One result can leave every cycle. A
// decode passes two pipelined modulo units (three stages for the offset table index,
// four for the colour table index) and the registered read of each table memory.
// The result channel has no back-pressure: the receiver must take every strobe.
// Every command walks the same in-order pipeline and writes or reads each table at
// one fixed stage, so a write always lands before any later decode reads it.
// Reset clears the pipeline and sets both table sizes to 1; table contents are
// not cleared and must be written before use. The user must write the size
// registers through cfg_we_i/cfg_idx_i/cfg_data_i only while no command is in
// flight; the block itself does not enforce that.
module spatial_hash_pixel_decoder_core import shpd_pkg::*; #(
  parameter int OFFSET_DIM = OFFSET_DIM_DEF,
  parameter int COLOR_DIM  = COLOR_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  shpd_in_t              in_i,
  output logic                  done_o,
  output shpd_out_t             out_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int OSW    = $clog2(OFFSET_DIM + 1);
  localparam int CSW    = $clog2(COLOR_DIM + 1);
  localparam int ODEPTH = OFFSET_DIM * OFFSET_DIM;
  localparam int CDEPTH = COLOR_DIM * COLOR_DIM;
  localparam int OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int HW     = COORD_W + 1;
  localparam int SIDE_W = $bits(shpd_side_t);
  localparam int N_OFF  = (COORD_W + MOD_STEP - 1) / MOD_STEP;
  localparam int N_COL  = (HW + MOD_STEP - 1) / MOD_STEP;
  localparam int RESULT_LAT = N_OFF + N_COL + 2;

  // Table size registers, clamped to 1..DIM on write.
  logic [OSW-1:0]       off_size_q, off_size_d;
  logic [CSW-1:0]       col_size_q, col_size_d;
  logic [OFF_REG_W-1:0] off_v;
  logic [COL_REG_W-1:0] col_v;

  always_comb begin
    off_v = cfg_data_i[OFF_REG_W-1:0];
    col_v = cfg_data_i[COL_REG_W-1:0];
    if (off_v == '0) begin
      off_size_d = OSW'(1);
    end else if (int'(off_v) > OFFSET_DIM) begin
      off_size_d = OSW'(OFFSET_DIM);
    end else begin
      off_size_d = OSW'(off_v);
    end
    if (col_v == '0) begin
      col_size_d = CSW'(1);
    end else if (int'(col_v) > COLOR_DIM) begin
      col_size_d = CSW'(COLOR_DIM);
    end else begin
      col_size_d = CSW'(col_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_size_q <= OSW'(1);
      col_size_q <= CSW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OFFSET_SIZE) begin
        off_size_q <= off_size_d;
      end
      if (cfg_idx_i == CFG_COLOR_SIZE) begin
        col_size_q <= col_size_d;
      end
    end
  end

  assign busy = 1'b0;

  // Command intake.
  logic       launch;
  shpd_side_t side_in;

  always_comb begin
    unique case (in_i.func)
      FUNC_WR_SHIFT: launch = (in_i.coord_x < COORD_W'(off_size_q)) &&
                              (in_i.coord_y < COORD_W'(off_size_q));
      FUNC_WR_COLOR: launch = (in_i.coord_x < COORD_W'(col_size_q)) &&
                              (in_i.coord_y < COORD_W'(col_size_q));
      FUNC_DECODE:   launch = 1'b1;
      FUNC_NOP:      launch = 1'b0;
    endcase
    launch = launch && start && !busy;

    side_in.func        = in_i.func;
    side_in.occupied    = in_i.occupied;
    side_in.coord_x     = in_i.coord_x;
    side_in.coord_y     = in_i.coord_y;
    side_in.shift_x     = in_i.shift_x;
    side_in.shift_y     = in_i.shift_y;
    side_in.pixel_color = in_i.pixel_color;
  end

  // Offset table index. An in-range write coordinate is its own remainder.
  logic              off_vld;
  logic [OSW-1:0]    ox, oy;
  logic [SIDE_W-1:0] off_side_raw;
  shpd_side_t        off_side;

  shpd_modpipe #(
    .DW   (COORD_W),
    .MW   (OSW),
    .SW   (SIDE_W),
    .STEP (MOD_STEP)
  ) u_off_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (launch),
    .a_i     (in_i.coord_x),
    .b_i     (in_i.coord_y),
    .mod_i   (off_size_q),
    .side_i  (side_in),
    .valid_o (off_vld),
    .ra_o    (ox),
    .rb_o    (oy),
    .side_o  (off_side_raw)
  );

  assign off_side = shpd_side_t'(off_side_raw);

  logic [OAW-1:0]           shift_addr;
  logic                     shift_we, shift_re;
  logic [2*SHIFT_W-1:0]     shift_rdata;

  assign shift_addr = OAW'(oy) * OAW'(OFFSET_DIM) + OAW'(ox);
  assign shift_we   = off_vld && (off_side.func == FUNC_WR_SHIFT);
  assign shift_re   = off_vld && (off_side.func == FUNC_DECODE) && off_side.occupied;

  shpd_ram #(
    .W     (2 * SHIFT_W),
    .DEPTH (ODEPTH)
  ) u_shift_ram (
    .clk_i   (clk_i),
    .we_i    (shift_we),
    .waddr_i (shift_addr),
    .wdata_i ({off_side.shift_y, off_side.shift_x}),
    .re_i    (shift_re),
    .raddr_i (shift_addr),
    .rdata_o (shift_rdata)
  );

  // Shift read stage.
  logic       r_vld_q;
  shpd_side_t r_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= off_vld && (off_side.func != FUNC_WR_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    r_side_q <= off_side;
  end

  logic          use_shift;
  logic [HW-1:0] hx_in, hy_in;

  always_comb begin
    use_shift = (r_side_q.func == FUNC_DECODE) && r_side_q.occupied;
    hx_in = HW'(r_side_q.coord_x);
    hy_in = HW'(r_side_q.coord_y);
    if (use_shift) begin
      hx_in = hx_in + HW'(shift_rdata[SHIFT_W-1:0]);
      hy_in = hy_in + HW'(shift_rdata[2*SHIFT_W-1:SHIFT_W]);
    end
  end

  // Colour table index.
  logic              col_vld;
  logic [CSW-1:0]    hx, hy;
  logic [SIDE_W-1:0] col_side_raw;
  shpd_side_t        col_side;

  shpd_modpipe #(
    .DW   (HW),
    .MW   (CSW),
    .SW   (SIDE_W),
    .STEP (MOD_STEP)
  ) u_col_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_vld_q),
    .a_i     (hx_in),
    .b_i     (hy_in),
    .mod_i   (col_size_q),
    .side_i  (r_side_q),
    .valid_o (col_vld),
    .ra_o    (hx),
    .rb_o    (hy),
    .side_o  (col_side_raw)
  );

  assign col_side = shpd_side_t'(col_side_raw);

  logic [CAW-1:0]     color_addr;
  logic               color_we, color_re;
  logic [COLOR_W-1:0] color_rdata;

  assign color_addr = CAW'(hy) * CAW'(COLOR_DIM) + CAW'(hx);
  assign color_we   = col_vld && (col_side.func == FUNC_WR_COLOR);
  assign color_re   = col_vld && (col_side.func == FUNC_DECODE) && col_side.occupied;

  shpd_ram #(
    .W     (COLOR_W),
    .DEPTH (CDEPTH)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (color_addr),
    .wdata_i (col_side.pixel_color),
    .re_i    (color_re),
    .raddr_i (color_addr),
    .rdata_o (color_rdata)
  );

  // Result stage: the colour memory's read register is the output register.
  logic f_vld_q;
  logic f_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= col_vld && (col_side.func == FUNC_DECODE);
    end
  end

  always_ff @(posedge clk_i) begin
    f_present_q <= col_side.occupied;
  end

  assign done_o              = f_vld_q;
  assign out_o.present       = f_present_q;
  assign out_o.decoded_color = f_present_q ? color_rdata : '0;

`ifndef SYNTHESIS
  a_result_follows_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && (in_i.func == FUNC_DECODE), RESULT_LAT))
    else $error("result strobe without a matching decode command");

  a_present_follows_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.present) |-> $past(in_i.occupied, RESULT_LAT))
    else $error("present result for a pixel taken as unoccupied");

  a_shift_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(shift_we && shift_re) && !(color_we && color_re))
    else $error("table memory written and read in the same cycle");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_size_q != '0) && (int'(off_size_q) <= OFFSET_DIM) &&
    (col_size_q != '0) && (int'(col_size_q) <= COLOR_DIM))
    else $error("table size register out of range");
`endif

endmodule

@@ tb/spatial_hash_pixel_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module spatial_hash_pixel_decoder_core_tb;
  import shpd_pkg::*;

  localparam int OFF_DIM = OFFSET_DIM_DEF;
  localparam int COL_DIM = COLOR_DIM_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 140;

  typedef enum {CMD_DROPPED, CMD_STORED, CMD_RESULT} cmd_effect_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  shpd_in_t              in_i;
  logic                  done_o;
  shpd_out_t             out_o;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of both tables; the valid bits keep decodes away from
  // entries that were never loaded.
  logic [7:0]         shift_mem   [OFF_DIM*OFF_DIM];
  bit                 shift_valid [OFF_DIM*OFF_DIM];
  logic [COLOR_W-1:0] color_mem   [COL_DIM*COL_DIM];
  bit                 color_valid [COL_DIM*COL_DIM];
  int unsigned        off_size = 1;
  int unsigned        col_size = 1;

  shpd_out_t pixel_q[$];
  int        fail_cnt = 0;
  int        useful_cnt = 0;
  bit        idle_en = 1'b1;

  spatial_hash_pixel_decoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned dim);
    if (v == 0) return 1;
    if (v > dim) return dim;
    return v;
  endfunction

  // Applies one command to the shadow tables and works out its pixel, if any.
  function automatic cmd_effect_e model_cmd(input shpd_in_t c, output shpd_out_t res);
    int unsigned ox, oy, hx, hy;
    logic [7:0]  pair;
    res = '0;
    case (c.func)
      FUNC_WR_SHIFT: begin
        if (c.coord_x < off_size && c.coord_y < off_size) begin
          shift_mem[c.coord_y*OFF_DIM + c.coord_x] = {c.shift_y, c.shift_x};
          shift_valid[c.coord_y*OFF_DIM + c.coord_x] = 1'b1;
          return CMD_STORED;
        end
      end
      FUNC_WR_COLOR: begin
        if (c.coord_x < col_size && c.coord_y < col_size) begin
          color_mem[c.coord_y*COL_DIM + c.coord_x] = c.pixel_color;
          color_valid[c.coord_y*COL_DIM + c.coord_x] = 1'b1;
          return CMD_STORED;
        end
      end
      FUNC_DECODE: begin
        if (c.occupied) begin
          ox = c.coord_x % off_size;
          oy = c.coord_y % off_size;
          pair = shift_mem[oy*OFF_DIM + ox];
          hx = (c.coord_x + pair[3:0]) % col_size;
          hy = (c.coord_y + pair[7:4]) % col_size;
          res.present = 1'b1;
          res.decoded_color = color_mem[hy*COL_DIM + hx];
        end
        return CMD_RESULT;
      end
      default: ;
    endcase
    return CMD_DROPPED;
  endfunction

  function automatic shpd_in_t rand_cmd();
    shpd_in_t c;
    c.func        = shpd_func_e'(2'($urandom_range(3)));
    c.coord_x     = COORD_W'($urandom_range(4095));
    c.coord_y     = COORD_W'($urandom_range(4095));
    c.occupied    = 1'($urandom_range(1));
    c.shift_x     = SHIFT_W'($urandom_range(15));
    c.shift_y     = SHIFT_W'($urandom_range(15));
    c.pixel_color = COLOR_W'($urandom_range(24'hFFFFFF));
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic issue_cmd(input shpd_in_t c);
    shpd_out_t res;
    while (idle_en && $urandom_range(99) < 24) begin
      start <= 1'b0;
      in_i  <= rand_cmd();
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (model_cmd(c, res))
      CMD_RESULT: begin
        pixel_q.insert(pixel_q.size(), res);
        useful_cnt++;
      end
      CMD_STORED: useful_cnt++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input shpd_cfg_e idx, input logic [7:0] raw);
    // Table writes leave no result behind, so give them time to retire too.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OFFSET_SIZE) off_size = clamp_dim(raw & 8'h3F, OFF_DIM);
    else col_size = clamp_dim(raw, COL_DIM);
  endtask

  task automatic set_sizes(input logic [7:0] raw_off, input logic [7:0] raw_col);
    write_size(CFG_OFFSET_SIZE, raw_off);
    write_size(CFG_COLOR_SIZE, raw_col);
  endtask

  task automatic put_shift(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy);
    shpd_in_t c;
    c = rand_cmd();
    c.func    = FUNC_WR_SHIFT;
    c.coord_x = x;
    c.coord_y = y;
    c.shift_x = sx;
    c.shift_y = sy;
    issue_cmd(c);
  endtask

  task automatic put_color(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COLOR_W-1:0] rgb);
    shpd_in_t c;
    c = rand_cmd();
    c.func        = FUNC_WR_COLOR;
    c.coord_x     = x;
    c.coord_y     = y;
    c.pixel_color = rgb;
    issue_cmd(c);
  endtask

  // An occupied decode first loads whichever table entries it would touch
  // that hold nothing yet.
  task automatic decode_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic occ);
    shpd_in_t    c;
    int unsigned ox, oy, hx, hy;
    logic [7:0]  pair;
    if (occ) begin
      ox = x % off_size;
      oy = y % off_size;
      if (!shift_valid[oy*OFF_DIM + ox])
        put_shift(COORD_W'(ox), COORD_W'(oy), SHIFT_W'($urandom_range(15)),
                  SHIFT_W'($urandom_range(15)));
      pair = shift_mem[oy*OFF_DIM + ox];
      hx = (x + pair[3:0]) % col_size;
      hy = (y + pair[7:4]) % col_size;
      if (!color_valid[hy*COL_DIM + hx])
        put_color(COORD_W'(hx), COORD_W'(hy), COLOR_W'($urandom_range(24'hFFFFFF)));
    end
    c = rand_cmd();
    c.func     = FUNC_DECODE;
    c.coord_x  = x;
    c.coord_y  = y;
    c.occupied = occ;
    issue_cmd(c);
  endtask

  task automatic random_step();
    int          sel;
    int unsigned lim;
    shpd_in_t    c;
    sel = $urandom_range(99);
    if (sel < 55) begin
      decode_pixel(pick_coord(), pick_coord(), 1'b1);
    end else if (sel < 68) begin
      decode_pixel(pick_coord(), pick_coord(), 1'b0);
    end else if (sel < 80) begin
      put_shift(COORD_W'($urandom_range(off_size - 1)), COORD_W'($urandom_range(off_size - 1)),
                SHIFT_W'($urandom_range(15)), SHIFT_W'($urandom_range(15)));
    end else if (sel < 90) begin
      put_color(COORD_W'($urandom_range(col_size - 1)), COORD_W'($urandom_range(col_size - 1)),
                COLOR_W'($urandom_range(24'hFFFFFF)));
    end else if (sel < 96) begin
      // A write that lands outside the table in use must leave it untouched.
      c = rand_cmd();
      c.func = $urandom_range(1) ? FUNC_WR_SHIFT : FUNC_WR_COLOR;
      lim = (c.func == FUNC_WR_SHIFT) ? off_size : col_size;
      if ($urandom_range(1)) c.coord_x = COORD_W'($urandom_range(4095, lim));
      else c.coord_y = COORD_W'($urandom_range(4095, lim));
      issue_cmd(c);
    end else begin
      c = rand_cmd();
      c.func = FUNC_NOP;
      issue_cmd(c);
    end
  endtask

  task automatic run_phase(input logic [7:0] raw_off, input logic [7:0] raw_col,
                           input int n, input bit pause_mid);
    int target;
    set_sizes(raw_off, raw_col);
    for (int half = 0; half < 2; half++) begin
      target = useful_cnt + ((half == 0) ? n / 2 : n - n / 2);
      while (useful_cnt < target) random_step();
      if (pause_mid && half == 0) wait_drained();
    end
  endtask

  task automatic test_reset_sizes();
    shpd_in_t c;
    put_shift(0, 0, 4'hF, 4'hF);
    put_color(0, 0, 24'hFFFFFF);
    decode_pixel(12'hFFF, 12'hFFF, 1'b1);
    decode_pixel(0, 0, 1'b0);
    put_color(1, 0, 24'h000000);
    put_color(0, 12'hFFF, 24'h000000);
    put_shift(12'hFFF, 0, 4'h0, 4'h0);
    c = rand_cmd();
    c.func = FUNC_NOP;
    issue_cmd(c);
    decode_pixel(0, 0, 1'b1);
  endtask

  task automatic test_size_extremes();
    set_sizes(8'h20, 8'h80);
    put_shift(31, 31, 4'hF, 4'h0);
    decode_pixel(12'hFFF, 12'hFFF, 1'b1);
    decode_pixel(0, 0, 1'b1);
    put_color(127, 127, 24'h000000);
    decode_pixel(12'hFFF, 12'hFFF, 1'b1);
    // Zero after masking falls back to a size of one.
    set_sizes(8'h40, 8'h00);
    decode_pixel(12'hFFF, 0, 1'b1);
    set_sizes(8'hFF, 8'hFF);
    decode_pixel(12'hFFF, 12'hFFF, 1'b1);
    decode_pixel(12'h800, 12'h7FF, 1'b0);
  endtask

  task automatic test_random_traffic();
    run_phase(8'h03, 8'h05, PHASE_ITEMS, 1'b0);
    run_phase(8'hFF, 8'hFF, PHASE_ITEMS, 1'b0);
    run_phase(8'h00, 8'h80, PHASE_ITEMS, 1'b0);
    run_phase(8'h20, 8'h01, PHASE_ITEMS, 1'b0);
    repeat (4) run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), PHASE_ITEMS, 1'b0);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 16)), PHASE_ITEMS, 1'b0);
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), PHASE_ITEMS, 1'b1);
  endtask

  always @(posedge clk_i) begin
    shpd_out_t want;
    if (rst_ni && done_o) begin
      if (pixel_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: unexpected pixel present=%0b color=%06h",
                   $realtime, out_o.present, out_o.decoded_color);
      end else begin
        want = pixel_q.pop_front();
        if (out_o.present !== want.present || out_o.decoded_color !== want.decoded_color)
        begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: pixel mismatch present exp=%0b got=%0b color exp=%06h got=%06h",
                     $realtime, want.present, out_o.present,
                     want.decoded_color, out_o.decoded_color);
        end
      end
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    in_i       <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_OFFSET_SIZE;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sizes();
    test_size_extremes();
    test_random_traffic();
    test_back_to_back();
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/shpd_pkg.sv
src/shpd_ram.sv
src/shpd_modpipe.sv
src/spatial_hash_pixel_decoder_core.sv
tb/spatial_hash_pixel_decoder_core_tb.sv
